/* rtl/fxh_pkg.sv */
// ----------------------------------------------------------------------------
// FxHash bucketed table package
// Shared types, constants and helper functions for the hash table.
// ----------------------------------------------------------------------------
package fxh_pkg;

  localparam int unsigned BucketsDef = 16;
  localparam int unsigned SlotsDef = 5;
  localparam int unsigned ValueBitsDef = 32;
  localparam logic [63:0] FxMul = 64'h517cc1b727220a95;
  localparam int unsigned FxRot = 5;
  localparam logic [3:0] KeyBytesRst = 4'd8;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncGet = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncNone = 2'd3;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusMiss = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic        table_empty;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StHash,
    StMulLo,
    StMulHi,
    StFetch,
    StScan,
    StShift,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic fold_start;
    logic mul_lo;
    logic mul_hi;
    logic fetch;
    logic scan;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more_chunks;
    logic scan_done;
    logic shift_done;
    logic need_shift;
  } sts_t;

  function automatic logic [3:0] eff_len(input logic [3:0] kb);
    logic [3:0] r;
    r = kb;
    if (kb == 4'd0) r = 4'd1;
    else if (kb > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(n)) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

/* rtl/fxhash_bucketed_hash_table.sv */
// ----------------------------------------------------------------------------
// FxHash bucketed hash table
// Key/value table with insert, get and remove over fixed-size buckets.
// ----------------------------------------------------------------------------
// One request is handled at a time. The hash always steps through the four
// chunk sizes, each through the hash, low-multiply and high-multiply states,
// folding in the sizes that fit the key. The bucket is then fetched and
// scanned one slot at a time from the single-port slot memory, each slot read
// before it is compared, and a remove then shifts the later slots down, each
// read and then written one slot lower. The controller returns to idle as the
// result is shown, so the next input can be taken in the same cycle; a result
// that is not yet taken holds the next request in its done state. The split
// multiply and the single slot memory port set the pace.
module fxhash_bucketed_hash_table #(
  parameter int unsigned BUCKETS = fxh_pkg::BucketsDef,
  parameter int unsigned SLOTS_PER_BUCKET = fxh_pkg::SlotsDef,
  parameter int unsigned VALUE_BITS = fxh_pkg::ValueBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fxh_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fxh_pkg::rsp_t out_data_o
);

  fxh_pkg::cmd_t cmd;
  fxh_pkg::sts_t sts;

  fxh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fxh_datapath #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .VALUE_BITS       (VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (out_data_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("more than one datapath command");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_ready_o) else $error("load outside idle");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o) else $error("finished result not shown");

endmodule

/* rtl/fxh_ctrl.sv */
// ----------------------------------------------------------------------------
// FxHash table controller
// Sequences hashing, bucket scan, shift and result transfer.
// ----------------------------------------------------------------------------
module fxh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fxh_pkg::sts_t sts_i,
  output fxh_pkg::cmd_t cmd_o
);

  fxh_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fxh_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      fxh_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = fxh_pkg::StHash;
        end
      end
      fxh_pkg::StHash: begin
        if (sts_i.more_chunks) begin
          cmd_o.fold_start = 1'b1;
          state_d = fxh_pkg::StMulLo;
        end else begin
          state_d = fxh_pkg::StFetch;
        end
      end
      fxh_pkg::StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d = fxh_pkg::StMulHi;
      end
      fxh_pkg::StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d = fxh_pkg::StHash;
      end
      fxh_pkg::StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d = fxh_pkg::StScan;
      end
      fxh_pkg::StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.need_shift ? fxh_pkg::StShift : fxh_pkg::StDone;
        end
      end
      fxh_pkg::StShift: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) state_d = fxh_pkg::StDone;
      end
      fxh_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = fxh_pkg::StIdle;
        end
      end
      default: state_d = fxh_pkg::StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/fxh_datapath.sv */
// ----------------------------------------------------------------------------
// FxHash table datapath
// Hash folding, bucket fill counts, slot memories and result register.
// ----------------------------------------------------------------------------
module fxh_datapath #(
  parameter int unsigned BUCKETS = fxh_pkg::BucketsDef,
  parameter int unsigned SLOTS_PER_BUCKET = fxh_pkg::SlotsDef,
  parameter int unsigned VALUE_BITS = fxh_pkg::ValueBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_data_i,
  input  fxh_pkg::req_t req_i,
  input  fxh_pkg::cmd_t cmd_i,
  output fxh_pkg::sts_t sts_o,
  output fxh_pkg::rsp_t rsp_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned Total = BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned AW = (Total > 1) ? $clog2(Total) : 1;
  localparam int unsigned SW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned TW = $clog2(Total + 1);
  localparam int unsigned VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic [3:0]  kb_q;
  logic [3:0]  len_q;
  logic [63:0] km_q;
  logic [1:0]  func_q;
  logic [63:0] key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [63:0] h_q;
  logic [63:0] x_q;
  logic [63:0] lo_q;
  logic        fold_q;
  logic [3:0]  pos_q;
  logic [3:0]  sz_q;
  logic [BW-1:0] bkt_q;
  logic [SW-1:0] fill_q;
  logic [SW-1:0] idx_q;
  logic        found_q;
  logic        rd_pend_q;
  logic [AW-1:0] base_q;
  logic [TW-1:0] total_q;
  logic [SW-1:0] fills_q [BUCKETS];
  logic [63:0] keys_m [Total];
  logic [VALUE_BITS-1:0] vals_m [Total];
  logic [63:0] rk_q;
  logic [VALUE_BITS-1:0] rv_q;
  fxh_pkg::rsp_t rsp_q;

  logic [3:0]  rem;
  logic [63:0] chunk, rot;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] bkt_fill;
  logic        chunk_ok;
  logic        rd_hit;
  logic [63:0] lo_prod;
  logic [31:0] hi_prod;

  assign rem = len_q - pos_q;
  assign chunk_ok = (sz_q != 4'd0) && (rem >= sz_q);
  assign chunk = (key_q >> {pos_q[2:0], 3'b000}) & fxh_pkg::byte_mask(sz_q);
  assign rot = {h_q[63-fxh_pkg::FxRot:0], h_q[63:64-fxh_pkg::FxRot]};
  assign bkt_fill = fills_q[BW'(h_q)];
  assign rd_addr = AW'(base_q + AW'(idx_q));
  assign wr_addr = AW'(base_q + AW'(idx_q) - AW'(1));
  assign rd_hit = ((rk_q & km_q) == key_q);
  assign lo_prod = x_q[31:0] * fxh_pkg::FxMul[31:0];
  assign hi_prod = x_q[63:32] * fxh_pkg::FxMul[31:0] +
                   x_q[31:0] * fxh_pkg::FxMul[63:32];

  assign sts_o.more_chunks = (sz_q != 4'd0);
  assign sts_o.scan_done = (func_q == fxh_pkg::FuncInsert) || (func_q == fxh_pkg::FuncNone) ||
                           found_q || (rd_pend_q && rd_hit) ||
                           (!rd_pend_q && idx_q >= fill_q);
  assign sts_o.need_shift = (func_q == fxh_pkg::FuncRemove) && !found_q &&
                            rd_pend_q && rd_hit;
  assign sts_o.shift_done = (idx_q >= fill_q) && !rd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_q <= fxh_pkg::KeyBytesRst;
      total_q <= '0;
      for (int i = 0; i < BUCKETS; i++) fills_q[i] <= '0;
      rsp_q <= '0;
    end else begin
      if (cfg_we_i) kb_q <= cfg_data_i;
      if (cmd_i.finish) begin
        rsp_q.value_out <= '0;
        rsp_q.status <= fxh_pkg::StatusOk;
        if (func_q == fxh_pkg::FuncInsert) begin
          if (fill_q < SW'(SLOTS_PER_BUCKET)) begin
            fills_q[bkt_q] <= fill_q + SW'(1);
            total_q <= total_q + TW'(1);
            rsp_q.table_empty <= 1'b0;
          end else begin
            rsp_q.status <= fxh_pkg::StatusFull;
            rsp_q.table_empty <= (total_q == '0);
          end
        end else if (func_q == fxh_pkg::FuncGet) begin
          rsp_q.table_empty <= (total_q == '0);
          if (found_q) rsp_q.value_out <= 32'(rv_q[VB-1:0]);
          else rsp_q.status <= fxh_pkg::StatusMiss;
        end else if (func_q == fxh_pkg::FuncRemove) begin
          if (found_q) begin
            fills_q[bkt_q] <= fill_q - SW'(1);
            total_q <= total_q - TW'(1);
            rsp_q.table_empty <= (total_q == TW'(1));
          end else begin
            rsp_q.status <= fxh_pkg::StatusMiss;
            rsp_q.table_empty <= (total_q == '0);
          end
        end else begin
          rsp_q.table_empty <= (total_q == '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q <= fxh_pkg::eff_len(kb_q);
      km_q <= fxh_pkg::byte_mask(fxh_pkg::eff_len(kb_q));
      func_q <= req_i.func;
      key_q <= req_i.key & fxh_pkg::byte_mask(fxh_pkg::eff_len(kb_q));
      val_q <= VALUE_BITS'(req_i.value);
      h_q <= '0;
      pos_q <= '0;
      sz_q <= 4'd8;
    end
    if (cmd_i.fold_start) begin
      if (chunk_ok) begin
        x_q <= rot ^ chunk;
        pos_q <= pos_q + sz_q;
      end
      fold_q <= chunk_ok;
      sz_q <= sz_q >> 1;
    end
    if (cmd_i.mul_lo) begin
      lo_q <= lo_prod;
    end
    // A chunk size that does not fit the remaining key bytes leaves the hash unchanged.
    if (cmd_i.mul_hi && fold_q) begin
      h_q <= lo_q + {hi_prod, 32'd0};
    end
    if (cmd_i.fetch) begin
      bkt_q <= BW'(h_q);
      fill_q <= (bkt_fill > SW'(SLOTS_PER_BUCKET)) ? SW'(SLOTS_PER_BUCKET) : bkt_fill;
      base_q <= AW'(BW'(h_q) * SLOTS_PER_BUCKET);
      idx_q <= '0;
      found_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (rd_pend_q) begin
        rd_pend_q <= 1'b0;
        if (rd_hit) begin
          found_q <= 1'b1;
        end
      end else if (idx_q < fill_q && func_q != fxh_pkg::FuncInsert) begin
        rk_q <= keys_m[rd_addr];
        rv_q <= vals_m[rd_addr];
        idx_q <= idx_q + SW'(1);
        rd_pend_q <= 1'b1;
      end
    end
    if (cmd_i.shift) begin
      if (rd_pend_q) begin
        keys_m[AW'(wr_addr - AW'(1))] <= rk_q;
        vals_m[AW'(wr_addr - AW'(1))] <= rv_q;
        rd_pend_q <= 1'b0;
      end else if (idx_q < fill_q) begin
        rk_q <= keys_m[rd_addr];
        rv_q <= vals_m[rd_addr];
        idx_q <= idx_q + SW'(1);
        rd_pend_q <= 1'b1;
      end
      if (!found_q) found_q <= 1'b1;
    end
    if (cmd_i.finish && func_q == fxh_pkg::FuncInsert && fill_q < SW'(SLOTS_PER_BUCKET)) begin
      keys_m[AW'(base_q + AW'(fill_q))] <= key_q;
      vals_m[AW'(base_q + AW'(fill_q))] <= val_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule
